FILE: design/irpdt_pkg.sv
// Package for the infrared pulse-distance transmitter core.
// Holds word types, register map, operation codes and sequencer phases.
// No dependencies; used by ir_pulse_distance_transmitter_core, irpdt_frame_checker and tb.
`default_nettype none

package irpdt_pkg;

	// Frame geometry and field widths
	localparam int DATA_BITS  = 8;
	localparam int BYTE_W     = 8;
	localparam int BIT_POS_W  = 3;
	localparam int TICK_W     = 10;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register reset values (ticks)
	localparam logic [TICK_W-1:0] MARK_TICKS_RST        = TICK_W'(10);
	localparam logic [TICK_W-1:0] START_SPACE_TICKS_RST = TICK_W'(30);
	localparam logic [TICK_W-1:0] ONE_SPACE_TICKS_RST   = TICK_W'(20);
	localparam logic [TICK_W-1:0] ZERO_SPACE_TICKS_RST  = TICK_W'(10);

	// Register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_MARK        = 2'd0,
		REG_START_SPACE = 2'd1,
		REG_ONE_SPACE   = 2'd2,
		REG_ZERO_SPACE  = 2'd3
	} reg_idx_t;

	// Operation codes of an input word
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Sequencer phases, one-hot
	typedef enum logic [7:0] {
		PH_IDLE        = 8'b0000_0001,
		PH_START_MARK  = 8'b0000_0010,
		PH_START_SPACE = 8'b0000_0100,
		PH_BIT_MARK    = 8'b0000_1000,
		PH_BIT_SPACE   = 8'b0001_0000,
		PH_STOP_MARK   = 8'b0010_0000,
		PH_STOP_SPACE  = 8'b0100_0000,
		PH_FINAL_MARK  = 8'b1000_0000
	} phase_t;

	// Input word
	typedef struct packed {
		logic              operation;
		logic [BYTE_W-1:0] data_byte;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic carrier_on;
		logic busy_res;
		logic load_rejected;
	} out_word_t;

endpackage

`default_nettype wire

FILE: design/ir_pulse_distance_transmitter_core.sv
// Top level of the infrared pulse-distance transmitter core.
// Depends on irpdt_pkg for word types, register map and phases.
// Phase sequencer, segment counter, APB registers and output skid stage.
`default_nettype none

// Every input word yields exactly one registered result word; a word can be
// accepted in every cycle that in_ready is high. A load word (operation 0)
// starts a frame when idle and is flagged load_rejected when a frame is
// running; a tick word (operation 1) advances the segment counter. The frame
// is a start mark, a start space, DATA_BITS bits MSB first (mark plus one or
// zero space), then a stop mark, a start-length space and a final mark. The
// carrier gate is on during marks and while idle. Segment lengths come from
// four 10-bit APB registers at byte addresses 0, 4, 8 and 12; a length of 0
// acts as 1. Registers should be written only while the block is idle. The
// result register is backed by a one-word skid stage, so in_ready drops only
// when both hold words that the sink has not taken.
module ir_pulse_distance_transmitter_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// input channel
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  irpdt_pkg::in_word_t                  in_word,
	// result channel
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output irpdt_pkg::out_word_t                 out_word,
	// configuration port
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [irpdt_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire  [irpdt_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [irpdt_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready
);

	localparam int TW = irpdt_pkg::TICK_W;
	localparam int PW = irpdt_pkg::BIT_POS_W;

	// Configuration registers
	logic [TW-1:0] mark_ticks_q;
	logic [TW-1:0] start_space_ticks_q;
	logic [TW-1:0] one_space_ticks_q;
	logic [TW-1:0] zero_space_ticks_q;

	// Sequencer state
	irpdt_pkg::phase_t           phase_q, phase_d;
	logic [PW-1:0]               bit_pos_q, bit_pos_d;
	logic [irpdt_pkg::BYTE_W-1:0] shift_q, shift_d;
	logic [TW-1:0]               seg_q, seg_d;

	// Output register and skid stage
	logic                 out_v_q;
	irpdt_pkg::out_word_t out_q;
	logic                 skid_v_q;
	irpdt_pkg::out_word_t skid_q;

	logic                 accept;
	logic                 cfg_write;
	irpdt_pkg::reg_idx_t  cfg_idx;
	logic [TW-1:0]        seg_inc;
	logic [TW-1:0]        seg_len;
	logic [TW-1:0]        seg_len_eff;
	logic                 seg_done;
	logic                 rejected;
	irpdt_pkg::out_word_t res;

	assign accept    = in_valid && in_ready;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = irpdt_pkg::reg_idx_t'(paddr[irpdt_pkg::APB_ADDR_W-1:2]);

	// APB register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_ticks_q        <= irpdt_pkg::MARK_TICKS_RST;
			start_space_ticks_q <= irpdt_pkg::START_SPACE_TICKS_RST;
			one_space_ticks_q   <= irpdt_pkg::ONE_SPACE_TICKS_RST;
			zero_space_ticks_q  <= irpdt_pkg::ZERO_SPACE_TICKS_RST;
		end else if (cfg_write) begin
			case (cfg_idx)
				irpdt_pkg::REG_MARK:        mark_ticks_q        <= pwdata[TW-1:0];
				irpdt_pkg::REG_START_SPACE: start_space_ticks_q <= pwdata[TW-1:0];
				irpdt_pkg::REG_ONE_SPACE:   one_space_ticks_q   <= pwdata[TW-1:0];
				irpdt_pkg::REG_ZERO_SPACE:  zero_space_ticks_q  <= pwdata[TW-1:0];
				default: ;
			endcase
		end
	end

	// APB read mux
	always_comb begin
		prdata = '0;
		case (cfg_idx)
			irpdt_pkg::REG_MARK:        prdata[TW-1:0] = mark_ticks_q;
			irpdt_pkg::REG_START_SPACE: prdata[TW-1:0] = start_space_ticks_q;
			irpdt_pkg::REG_ONE_SPACE:   prdata[TW-1:0] = one_space_ticks_q;
			irpdt_pkg::REG_ZERO_SPACE:  prdata[TW-1:0] = zero_space_ticks_q;
			default:                    prdata = '0;
		endcase
	end

	// Length of the current segment; zero counts as one tick
	always_comb begin
		case (phase_q)
			irpdt_pkg::PH_START_SPACE,
			irpdt_pkg::PH_STOP_SPACE: seg_len = start_space_ticks_q;
			irpdt_pkg::PH_BIT_SPACE:  seg_len = shift_q[irpdt_pkg::DATA_BITS-1] ?
			                                    one_space_ticks_q : zero_space_ticks_q;
			default:                  seg_len = mark_ticks_q;
		endcase
		seg_len_eff = (seg_len == '0) ? TW'(1) : seg_len;
	end

	assign seg_inc  = seg_q + TW'(1);
	assign seg_done = (seg_inc >= seg_len_eff);

	// Next-state logic for one input word
	always_comb begin
		phase_d   = phase_q;
		bit_pos_d = bit_pos_q;
		shift_d   = shift_q;
		seg_d     = seg_q;
		rejected  = 1'b0;
		if (in_word.operation == irpdt_pkg::OP_LOAD) begin
			if (phase_q == irpdt_pkg::PH_IDLE) begin
				shift_d   = in_word.data_byte;
				bit_pos_d = '0;
				seg_d     = '0;
				phase_d   = irpdt_pkg::PH_START_MARK;
			end else begin
				rejected = 1'b1;
			end
		end else if (phase_q != irpdt_pkg::PH_IDLE) begin
			seg_d = seg_inc;
			if (seg_done) begin
				seg_d = '0;
				case (phase_q)
					irpdt_pkg::PH_START_MARK:  phase_d = irpdt_pkg::PH_START_SPACE;
					irpdt_pkg::PH_START_SPACE: phase_d = irpdt_pkg::PH_BIT_MARK;
					irpdt_pkg::PH_BIT_MARK:    phase_d = irpdt_pkg::PH_BIT_SPACE;
					irpdt_pkg::PH_BIT_SPACE: begin
						if (bit_pos_q >= PW'(irpdt_pkg::DATA_BITS - 1)) begin
							phase_d   = irpdt_pkg::PH_STOP_MARK;
							bit_pos_d = '0;
						end else begin
							phase_d   = irpdt_pkg::PH_BIT_MARK;
							bit_pos_d = bit_pos_q + PW'(1);
						end
						shift_d = shift_q << 1;
					end
					irpdt_pkg::PH_STOP_MARK:   phase_d = irpdt_pkg::PH_STOP_SPACE;
					irpdt_pkg::PH_STOP_SPACE:  phase_d = irpdt_pkg::PH_FINAL_MARK;
					default:                   phase_d = irpdt_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// Result word reflects the state after the item
	always_comb begin
		res.carrier_on    = !(phase_d inside {irpdt_pkg::PH_START_SPACE,
		                                      irpdt_pkg::PH_BIT_SPACE,
		                                      irpdt_pkg::PH_STOP_SPACE});
		res.busy_res      = (phase_d != irpdt_pkg::PH_IDLE);
		res.load_rejected = rejected;
	end

	// Sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= irpdt_pkg::PH_IDLE;
			bit_pos_q <= '0;
			shift_q   <= '0;
			seg_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			bit_pos_q <= bit_pos_d;
			shift_q   <= shift_d;
			seg_q     <= seg_d;
		end
	end

	// Output register plus skid stage
	assign in_ready  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload of output and skid words
	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

`ifndef ASSERT_OFF
	// Skid stage only fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word present without output word");

	// A stalled accept must land in the skid stage
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && out_v_q && !out_ready) |=> skid_v_q)
		else $error("accepted word lost during output stall");

	// A rejected load only happens during a frame
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.load_rejected) |-> out_q.busy_res)
		else $error("load rejected while not busy");

	// Idle leaves the counters cleared
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == irpdt_pkg::PH_IDLE) |-> (seg_q == '0 && bit_pos_q == '0))
		else $error("counters not cleared in idle");

	// Idle results always show the carrier on
	a_idle_carrier: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_q.busy_res) |-> out_q.carrier_on)
		else $error("carrier off while idle");
`endif

endmodule

`default_nettype wire

FILE: verif/irpdt_frame_checker.sv
// Checker for the infrared pulse-distance transmitter core: predicts each result word.
// Watches the input, result and APB channels, and compares results in order.
// Depends on irpdt_pkg for word types, register indexes and phases.
`default_nettype none

module irpdt_frame_checker (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	input  wire                                in_ready,
	input  irpdt_pkg::in_word_t                in_word,
	input  wire                                out_valid,
	input  wire                                out_ready,
	input  irpdt_pkg::out_word_t               out_word,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire                                pready,
	input  wire [irpdt_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire [irpdt_pkg::APB_DATA_W-1:0]    pwdata,
	output int                                 mismatches = 0,
	output int                                 pending_results = 0
);

	localparam int TW = irpdt_pkg::TICK_W;
	localparam int PW = irpdt_pkg::BIT_POS_W;

	// segment lengths as last written
	logic [TW-1:0] len_mark  = irpdt_pkg::MARK_TICKS_RST;
	logic [TW-1:0] len_start = irpdt_pkg::START_SPACE_TICKS_RST;
	logic [TW-1:0] len_one   = irpdt_pkg::ONE_SPACE_TICKS_RST;
	logic [TW-1:0] len_zero  = irpdt_pkg::ZERO_SPACE_TICKS_RST;

	// predicted sequencer state
	irpdt_pkg::phase_t               seq_phase  = irpdt_pkg::PH_IDLE;
	logic [PW-1:0]                   bit_idx    = '0;
	logic [irpdt_pkg::BYTE_W-1:0]    shift_reg  = '0;
	logic [TW-1:0]                   tick_count = '0;

	// result words still owed by the block, oldest first
	irpdt_pkg::out_word_t expected_levels[$];

	// length of the segment now running; zero counts as one tick
	function automatic logic [TW-1:0] segment_limit();
		logic [TW-1:0] lim;
		case (seq_phase)
			irpdt_pkg::PH_START_SPACE, irpdt_pkg::PH_STOP_SPACE: lim = len_start;
			irpdt_pkg::PH_BIT_SPACE:
				lim = shift_reg[irpdt_pkg::DATA_BITS-1] ? len_one : len_zero;
			default: lim = len_mark;
		endcase
		return (lim == '0) ? TW'(1) : lim;
	endfunction

	// move on to the following segment of the frame
	task automatic next_segment();
		case (seq_phase)
			irpdt_pkg::PH_START_MARK:  seq_phase = irpdt_pkg::PH_START_SPACE;
			irpdt_pkg::PH_START_SPACE: seq_phase = irpdt_pkg::PH_BIT_MARK;
			irpdt_pkg::PH_BIT_MARK:    seq_phase = irpdt_pkg::PH_BIT_SPACE;
			irpdt_pkg::PH_BIT_SPACE: begin
				if (bit_idx >= PW'(irpdt_pkg::DATA_BITS - 1)) begin
					seq_phase = irpdt_pkg::PH_STOP_MARK;
					bit_idx   = '0;
				end else begin
					seq_phase = irpdt_pkg::PH_BIT_MARK;
					bit_idx   = bit_idx + PW'(1);
				end
				shift_reg = shift_reg << 1;
			end
			irpdt_pkg::PH_STOP_MARK:   seq_phase = irpdt_pkg::PH_STOP_SPACE;
			irpdt_pkg::PH_STOP_SPACE:  seq_phase = irpdt_pkg::PH_FINAL_MARK;
			default:                   seq_phase = irpdt_pkg::PH_IDLE;
		endcase
	endtask

	// apply one input word and give the levels that follow it
	task automatic advance_transmitter(input irpdt_pkg::in_word_t w,
		output irpdt_pkg::out_word_t lvl);
		lvl.load_rejected = 1'b0;
		if (w.operation == irpdt_pkg::OP_LOAD) begin
			if (seq_phase == irpdt_pkg::PH_IDLE) begin
				shift_reg  = w.data_byte;
				bit_idx    = '0;
				tick_count = '0;
				seq_phase  = irpdt_pkg::PH_START_MARK;
			end else begin
				lvl.load_rejected = 1'b1;
			end
		end else if (seq_phase != irpdt_pkg::PH_IDLE) begin
			tick_count = tick_count + TW'(1);
			if (tick_count >= segment_limit()) begin
				tick_count = '0;
				next_segment();
			end
		end
		lvl.carrier_on = !(seq_phase == irpdt_pkg::PH_START_SPACE ||
			seq_phase == irpdt_pkg::PH_BIT_SPACE ||
			seq_phase == irpdt_pkg::PH_STOP_SPACE);
		lvl.busy_res = (seq_phase != irpdt_pkg::PH_IDLE);
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %b, got %b", $time, name, want, got);
		end
	endtask

	// results are checked before the word accepted at the same edge is applied
	always @(posedge clk or negedge arst_n) begin
		irpdt_pkg::out_word_t want;
		irpdt_pkg::out_word_t got;
		if (!arst_n) begin
			len_mark   = irpdt_pkg::MARK_TICKS_RST;
			len_start  = irpdt_pkg::START_SPACE_TICKS_RST;
			len_one    = irpdt_pkg::ONE_SPACE_TICKS_RST;
			len_zero   = irpdt_pkg::ZERO_SPACE_TICKS_RST;
			seq_phase  = irpdt_pkg::PH_IDLE;
			bit_idx    = '0;
			shift_reg  = '0;
			tick_count = '0;
			expected_levels.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result word %b with none expected", $time, out_word);
				end else begin
					want = expected_levels.pop_front();
					check_field("carrier_on", want.carrier_on, out_word.carrier_on);
					check_field("busy_res", want.busy_res, out_word.busy_res);
					check_field("load_rejected", want.load_rejected, out_word.load_rejected);
				end
			end
			if (in_valid && in_ready) begin
				advance_transmitter(in_word, got);
				expected_levels.push_back(got);
			end
			// register write completes at the access edge
			if (psel && penable && pwrite && pready) begin
				case (irpdt_pkg::reg_idx_t'(paddr[irpdt_pkg::APB_ADDR_W-1:2]))
					irpdt_pkg::REG_MARK:        len_mark  = pwdata[TW-1:0];
					irpdt_pkg::REG_START_SPACE: len_start = pwdata[TW-1:0];
					irpdt_pkg::REG_ONE_SPACE:   len_one   = pwdata[TW-1:0];
					irpdt_pkg::REG_ZERO_SPACE:  len_zero  = pwdata[TW-1:0];
					default: ;
				endcase
			end
		end
		pending_results = expected_levels.size();
	end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Top of the testbench for ir_pulse_distance_transmitter_core.
// Drives directed and random frames, register writes and random stalls; gives the verdict.
// Depends on irpdt_pkg, the core and irpdt_frame_checker.
`default_nettype none

module tb;

	localparam int TW = irpdt_pkg::TICK_W;
	localparam int BW = irpdt_pkg::BYTE_W;
	localparam int DW = irpdt_pkg::APB_DATA_W;

	logic                              clk;
	logic                              arst_n    = 1'b0;
	logic                              in_valid  = 1'b0;
	logic                              in_ready;
	irpdt_pkg::in_word_t               in_word   = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	irpdt_pkg::out_word_t              out_word;
	logic                              psel      = 1'b0;
	logic                              penable   = 1'b0;
	logic                              pwrite    = 1'b0;
	logic [irpdt_pkg::APB_ADDR_W-1:0]  paddr     = '0;
	logic [DW-1:0]                     pwdata    = '0;
	logic [DW-1:0]                     prdata;
	logic                              pready;

	int mismatches;
	int pending_results;

	// stimulus bookkeeping: lengths in force, ticks left in the frame
	logic [TW-1:0] mark_len  = irpdt_pkg::MARK_TICKS_RST;
	logic [TW-1:0] start_len = irpdt_pkg::START_SPACE_TICKS_RST;
	logic [TW-1:0] one_len   = irpdt_pkg::ONE_SPACE_TICKS_RST;
	logic [TW-1:0] zero_len  = irpdt_pkg::ZERO_SPACE_TICKS_RST;
	int            ticks_left = 0;
	int            words_sent = 0;
	int            send_idle_pct = 26;
	int            recv_idle_pct = 57;

	ir_pulse_distance_transmitter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	irpdt_frame_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_word         (in_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_word        (out_word),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sink stalls at random
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	function automatic int eff_len(input logic [TW-1:0] v);
		return (v == '0) ? 1 : int'(v);
	endfunction

	// ticks a whole frame takes for this byte at the current lengths
	function automatic int frame_ticks(input logic [BW-1:0] d);
		int ones;
		ones = $countones(d[irpdt_pkg::DATA_BITS-1:0]);
		return (3 + irpdt_pkg::DATA_BITS) * eff_len(mark_len) + 2 * eff_len(start_len) +
			ones * eff_len(one_len) + (irpdt_pkg::DATA_BITS - ones) * eff_len(zero_len);
	endfunction

	// one word on the input channel, with random gaps in front of it
	task automatic send_word(input irpdt_pkg::op_t op, input logic [BW-1:0] data_val);
		irpdt_pkg::in_word_t w;
		w.operation = op;
		w.data_byte = data_val;
		if (words_sent < 350) begin
			send_idle_pct = 26;
			recv_idle_pct = 57;
		end else if (words_sent < 700) begin
			send_idle_pct = 57;
			recv_idle_pct = 26;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		words_sent++;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		if (op == irpdt_pkg::OP_LOAD && ticks_left == 0)
			ticks_left = frame_ticks(data_val);
		else if (op == irpdt_pkg::OP_TICK && ticks_left > 0)
			ticks_left--;
	endtask

	task automatic finish_frame();
		while (ticks_left > 0)
			send_word(irpdt_pkg::OP_TICK, 8'($urandom_range(255)));
	endtask

	// psel stays high across back-to-back writes; garbage above the length field
	task automatic write_reg(input irpdt_pkg::reg_idx_t idx, input logic [TW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {(DW-TW)'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// new lengths, written only once the frame is over and all results are out
	task automatic set_lengths(input logic [TW-1:0] m, input logic [TW-1:0] s,
		input logic [TW-1:0] o, input logic [TW-1:0] z);
		finish_frame();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending_results == 0);
		@(posedge clk);
		write_reg(irpdt_pkg::REG_MARK, m);
		write_reg(irpdt_pkg::REG_START_SPACE, s);
		write_reg(irpdt_pkg::REG_ONE_SPACE, o);
		write_reg(irpdt_pkg::REG_ZERO_SPACE, z);
		psel    <= 1'b0;
		penable <= 1'b0;
		mark_len  = m;
		start_len = s;
		one_len   = o;
		zero_len  = z;
	endtask

	function automatic logic [TW-1:0] rand_len();
		return ($urandom_range(9) == 0) ? TW'(0) : TW'($urandom_range(1, 6));
	endfunction

	// mostly whole frames with random bytes; a few loads land mid-frame
	task automatic run_random(input int budget);
		for (int n = 0; n < budget; n++) begin
			if (ticks_left == 0)
				send_word(($urandom_range(99) < 85) ? irpdt_pkg::OP_LOAD : irpdt_pkg::OP_TICK,
					8'($urandom_range(255)));
			else
				send_word(($urandom_range(99) < 5) ? irpdt_pkg::OP_LOAD : irpdt_pkg::OP_TICK,
					8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset lengths: idle ticks, a frame, loads while busy
		send_word(irpdt_pkg::OP_TICK, 8'hFF);
		send_word(irpdt_pkg::OP_TICK, 8'h00);
		send_word(irpdt_pkg::OP_LOAD, 8'h5A);
		send_word(irpdt_pkg::OP_LOAD, 8'hFF);
		send_word(irpdt_pkg::OP_TICK, 8'hA5);
		send_word(irpdt_pkg::OP_LOAD, 8'h00);

		// shortest lengths: all-ones and all-zeros bytes
		set_lengths(TW'(1), TW'(1), TW'(1), TW'(1));
		send_word(irpdt_pkg::OP_LOAD, 8'hFF);
		send_word(irpdt_pkg::OP_LOAD, 8'h00);
		finish_frame();
		send_word(irpdt_pkg::OP_LOAD, 8'h00);
		finish_frame();
		send_word(irpdt_pkg::OP_TICK, 8'h55);

		// zero lengths first, then random short ones
		for (int k = 0; k < 7; k++) begin
			if (k == 0)
				set_lengths(TW'(0), TW'(0), TW'(0), TW'(0));
			else
				set_lengths(rand_len(), rand_len(), rand_len(), rand_len());
			run_random(50);
		end

		// longer, unequal lengths: one full frame with mixed bits
		set_lengths(TW'(9), TW'(14), TW'(7), TW'(4));
		send_word(irpdt_pkg::OP_LOAD, 8'($urandom_range(1, 254)));
		while (ticks_left > 0)
			send_word(($urandom_range(99) == 0) ? irpdt_pkg::OP_LOAD : irpdt_pkg::OP_TICK,
				8'($urandom_range(255)));

		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending_results == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results == 0)
			$display("** ir_pulse_distance_transmitter_core: PASSED **");
		else
			$display("** ir_pulse_distance_transmitter_core: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("** ir_pulse_distance_transmitter_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

FILE: ir_pulse_distance_transmitter_core.f
design/irpdt_pkg.sv
design/ir_pulse_distance_transmitter_core.sv
verif/irpdt_frame_checker.sv
verif/tb.sv
